// ===== hw/rtl/vdn_pkg.sv =====
// Shared types and fixed widths for the vector distance/normalize block.
// Used by every module under hw/rtl except vdn_isqrt; depends on nothing.
package vdn_pkg;

   localparam int CW       = 16;              // component width
   localparam int LFB      = 8;               // fraction bits of the length
   localparam int UFB      = 14;              // fraction bits of unit components
   localparam int DIFF_W   = CW + 1;
   localparam int SQ_W     = 2 * CW;
   localparam int DSQ_W    = 2 * CW + 2;
   localparam int LRAD_W   = DSQ_W + 2 * LFB;
   localparam int LROOT_W  = LRAD_W / 2;
   localparam int QUO_W    = 2 * UFB + 1;
   localparam int URAD_W   = 2 * UFB + 2;
   localparam int UROOT_W  = URAD_W / 2;
   localparam int DIV_ST   = QUO_W;
   localparam int USQ_ST   = UROOT_W;
   localparam int BACK_ST  = DIV_ST + USQ_ST;
   localparam int LEN_PAD  = BACK_ST - LROOT_W;
   localparam int QDEPTH   = 8;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = QPTR_W + 1;
   localparam int FRONT_ST = 3;
   localparam int INFL_W   = 2;

   localparam int DIST_OUT_W = 34;
   localparam int LEN_OUT_W  = 25;
   localparam int UNIT_OUT_W = 16;

   typedef struct packed {
      logic signed [CW-1:0] a_x;
      logic signed [CW-1:0] a_y;
      logic signed [CW-1:0] a_z;
      logic signed [CW-1:0] b_x;
      logic signed [CW-1:0] b_y;
      logic signed [CW-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic [DIST_OUT_W-1:0]        dist_squared;
      logic [LEN_OUT_W-1:0]         length_q8;
      logic signed [UNIT_OUT_W-1:0] unit_x;
      logic signed [UNIT_OUT_W-1:0] unit_y;
      logic signed [UNIT_OUT_W-1:0] unit_z;
      logic                         zero_length;
   } rsp_type;

   typedef struct packed {
      logic [DSQ_W-1:0]         dsq;
      logic [2:0][SQ_W-1:0]     msq;
      logic [2:0]               neg;
   } work_type;

   typedef struct packed {
      logic              push;
      logic [INFL_W-1:0] inflight;
   } front_status_type;

endpackage

// ===== hw/rtl/vector_distance_normalize.sv =====
// Pipeline: 49 register stages (3 front, 1 queue, 29 divide, 15 root, 1 out), the first
// loaded at the accepting edge; rsp_strobe rises as the last of them is loaded.
// Throughput: one item per cycle; the divide and root pipelines take a new item each cycle.
// busy rises only if the 8-entry queue could overflow, which the back end never lets happen.
// Reset (synchronous, active high) empties the queue and clears all valid bits.
// Results are strobed for one cycle; the receiver cannot stall.
module vector_distance_normalize (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vdn_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output vdn_pkg::rsp_type  rsp_item
);

   vdn_pkg::front_status_type status;
   vdn_pkg::work_type         front_work;
   vdn_pkg::work_type         queue_work;
   logic                      queue_valid;
   logic                      take;

   assign take = start && !busy;

   vdn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_item (req_item),
      .status   (status),
      .work     (front_work)
   );

   vdn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .wr_work  (front_work),
      .busy     (busy),
      .rd_valid (queue_valid),
      .rd_work  (queue_work)
   );

   vdn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_work    (queue_work),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   a_no_strobe_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.zero_length) |->
         (rsp_item.length_q8 == '0 && rsp_item.unit_x == '0 &&
          rsp_item.unit_y == '0 && rsp_item.unit_z == '0 &&
          rsp_item.dist_squared == '0))
      else $error("zero-length result carries nonzero fields");

   a_never_busy_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!queue_valid && status.inflight == '0) |-> !busy)
      else $error("busy with empty queue and front");

endmodule

// ===== hw/rtl/vdn_front.sv =====
// Front end: takes point pairs, forms differences, squares and squared length.
// Depends on vdn_pkg.
module vdn_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  vdn_pkg::req_type          req_item,
   output vdn_pkg::front_status_type status,
   output vdn_pkg::work_type         work
);

   logic [2:0]                                v_ff;
   logic signed [vdn_pkg::DIFF_W-1:0]         d_ff [3];
   logic [vdn_pkg::SQ_W-1:0]                  sq_ff [3];
   logic [2:0]                                neg1_ff;
   vdn_pkg::work_type                         work_ff;
   logic signed [vdn_pkg::DIFF_W-1:0]         a_ext [3];
   logic signed [vdn_pkg::DIFF_W-1:0]         b_ext [3];
   logic signed [2*vdn_pkg::DIFF_W-1:0]       prod [3];

   assign a_ext[0] = {req_item.a_x[vdn_pkg::CW-1], req_item.a_x};
   assign a_ext[1] = {req_item.a_y[vdn_pkg::CW-1], req_item.a_y};
   assign a_ext[2] = {req_item.a_z[vdn_pkg::CW-1], req_item.a_z};
   assign b_ext[0] = {req_item.b_x[vdn_pkg::CW-1], req_item.b_x};
   assign b_ext[1] = {req_item.b_y[vdn_pkg::CW-1], req_item.b_y};
   assign b_ext[2] = {req_item.b_z[vdn_pkg::CW-1], req_item.b_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = d_ff[i] * d_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], take};
      end
      for (int i = 0; i < 3; i++) begin
         d_ff[i]    <= a_ext[i] - b_ext[i];
         sq_ff[i]   <= prod[i][vdn_pkg::SQ_W-1:0];
         neg1_ff[i] <= d_ff[i][vdn_pkg::DIFF_W-1];
      end
      work_ff.msq   <= {sq_ff[2], sq_ff[1], sq_ff[0]};
      work_ff.neg   <= neg1_ff;
      work_ff.dsq   <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
   end

   assign status.push     = v_ff[2];
   assign status.inflight = {1'b0, v_ff[0]} + {1'b0, v_ff[1]} + {1'b0, v_ff[2]};
   assign work            = work_ff;

endmodule

// ===== hw/rtl/vdn_queue.sv =====
// Short queue between front and back end; raises busy when it may overflow.
// Depends on vdn_pkg.
module vdn_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  vdn_pkg::front_status_type status,
   input  vdn_pkg::work_type         wr_work,
   output logic                      busy,
   output logic                      rd_valid,
   output vdn_pkg::work_type         rd_work
);

   vdn_pkg::work_type              mem_ff [vdn_pkg::QDEPTH];
   logic [vdn_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [vdn_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [vdn_pkg::QCNT_W-1:0]     count_ff;
   logic [vdn_pkg::QCNT_W-1:0]     count_in;
   logic [vdn_pkg::QCNT_W-1:0]     need;

   // back end never stalls: pop whenever something is queued
   assign rd_valid = (count_ff != '0);
   assign rd_work  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (status.push && !rd_valid) begin
         count_in = count_ff + 1'b1;
      end else if (!status.push && rd_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign need = count_ff + vdn_pkg::QCNT_W'(status.inflight);
   assign busy = (need >= vdn_pkg::QCNT_W'(vdn_pkg::QDEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (status.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_valid) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (status.push) begin
         mem_ff[wr_ptr_ff] <= wr_work;
      end
   end

endmodule

// ===== hw/rtl/vdn_div.sv =====
// Pipelined restoring divider: floor(num * 2^(2*UFB) / den), one quotient bit a stage.
// Assumes num <= den. Depends on vdn_pkg.
module vdn_div (
   input  logic                       clock,
   input  logic [vdn_pkg::SQ_W-1:0]   num,
   input  logic [vdn_pkg::DSQ_W-1:0]  den,
   output logic [vdn_pkg::QUO_W-1:0]  quo
);

   localparam int DW = vdn_pkg::DSQ_W;
   localparam int QW = vdn_pkg::QUO_W;

   logic [DW-1:0] rem_ff [QW-1];
   logic [DW-1:0] den_ff [QW-1];
   logic [QW-1:0] q_ff   [QW];

   genvar k;
   for (k = 0; k < QW; k++) begin : g_step
      logic [DW:0]   r2;
      logic [DW:0]   sub;
      logic [DW-1:0] den_cur;
      logic [QW-1:0] q_cur;
      logic          ge;
      if (k == 0) begin : g_first
         assign r2      = {{(DW + 1 - vdn_pkg::SQ_W){1'b0}}, num};
         assign den_cur = den;
         assign q_cur   = '0;
      end else begin : g_next
         assign r2      = {rem_ff[k-1], 1'b0};
         assign den_cur = den_ff[k-1];
         assign q_cur   = q_ff[k-1];
      end
      assign sub = r2 - {1'b0, den_cur};
      assign ge  = (r2 >= {1'b0, den_cur});
      always_ff @(posedge clock) begin
         q_ff[k] <= {q_cur[QW-2:0], ge};
      end
      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= ge ? sub[DW-1:0] : r2[DW-1:0];
            den_ff[k] <= den_cur;
         end
      end
   end

   assign quo = q_ff[QW-1];

endmodule

// ===== hw/rtl/vdn_isqrt.sv =====
// Pipelined integer square root, one root bit a stage, plus PAD delay stages.
// Stand-alone datapath; no package use.
module vdn_isqrt #(
   parameter int RAD_W = 30,
   parameter int PAD   = 0
) (
   input  logic                 clock,
   input  logic [RAD_W-1:0]     rad,
   output logic [RAD_W/2-1:0]   root
);

   localparam int RW = RAD_W / 2;
   localparam int MW = RW + 3;

   logic [MW-1:0]    rem_ff  [RW-1];
   logic [RAD_W-1:0] rad_ff  [RW-1];
   logic [RW-1:0]    root_ff [RW];

   genvar k;
   for (k = 0; k < RW; k++) begin : g_step
      logic [MW-1:0]    rem_cur;
      logic [MW-1:0]    r2;
      logic [MW-1:0]    trial;
      logic [RW-1:0]    root_cur;
      logic [RAD_W-1:0] rad_cur;
      logic             ge;
      if (k == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rad_cur  = rad;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
      end
      assign r2    = {rem_cur[MW-3:0], rad_cur[RAD_W-1 -: 2]};
      assign trial = {1'b0, root_cur, 2'b01};
      assign ge    = (r2 >= trial);
      always_ff @(posedge clock) begin
         root_ff[k] <= {root_cur[RW-2:0], ge};
      end
      if (k < RW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= ge ? (r2 - trial) : r2;
            rad_ff[k] <= {rad_cur[RAD_W-3:0], 2'b00};
         end
      end
   end

   if (PAD == 0) begin : g_nopad
      assign root = root_ff[RW-1];
   end else begin : g_pad
      logic [RW-1:0] pad_ff [PAD];
      always_ff @(posedge clock) begin
         pad_ff[0] <= root_ff[RW-1];
         for (int i = 1; i < PAD; i++) begin
            pad_ff[i] <= pad_ff[i-1];
         end
      end
      assign root = pad_ff[PAD-1];
   end

endmodule

// ===== hw/rtl/vdn_back.sv =====
// Back end: length root, per-component divide and root, result register.
// Depends on vdn_pkg, vdn_div, vdn_isqrt.
module vdn_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  vdn_pkg::work_type  in_work,
   output logic               rsp_strobe,
   output vdn_pkg::rsp_type   rsp_item
);

   localparam int ST = vdn_pkg::BACK_ST;

   typedef struct packed {
      logic [vdn_pkg::DSQ_W-1:0] dsq;
      logic [2:0]                neg;
      logic                      zero;
   } side_type;

   side_type                          side_in;
   side_type                          side_ff [ST];
   logic [ST-1:0]                     valid_ff;
   logic [vdn_pkg::LROOT_W-1:0]       len_root;
   logic [vdn_pkg::QUO_W-1:0]         quo  [3];
   logic [vdn_pkg::UROOT_W-1:0]       uroot [3];
   logic signed [vdn_pkg::UNIT_OUT_W-1:0] unit_val [3];
   logic                              strobe_ff;
   vdn_pkg::rsp_type                  rsp_ff;
   vdn_pkg::rsp_type                  rsp_in;

   assign side_in.dsq  = in_work.dsq;
   assign side_in.neg  = in_work.neg;
   assign side_in.zero = (in_work.dsq == '0);

   vdn_isqrt #(
      .RAD_W (vdn_pkg::LRAD_W),
      .PAD   (vdn_pkg::LEN_PAD)
   ) u_len (
      .clock (clock),
      .rad   ({in_work.dsq, {(2 * vdn_pkg::LFB){1'b0}}}),
      .root  (len_root)
   );

   genvar c;
   for (c = 0; c < 3; c++) begin : g_comp
      vdn_div u_div (
         .clock (clock),
         .num   (in_work.msq[c]),
         .den   (in_work.dsq),
         .quo   (quo[c])
      );
      vdn_isqrt #(
         .RAD_W (vdn_pkg::URAD_W),
         .PAD   (0)
      ) u_usq (
         .clock (clock),
         .rad   ({{(vdn_pkg::URAD_W - vdn_pkg::QUO_W){1'b0}}, quo[c]}),
         .root  (uroot[c])
      );
      always_comb begin
         unit_val[c] = vdn_pkg::UNIT_OUT_W'(uroot[c]);
         if (side_ff[ST-1].zero) begin
            unit_val[c] = '0;
         end else if (side_ff[ST-1].neg[c]) begin
            unit_val[c] = -unit_val[c];
         end
      end
   end

   always_comb begin
      rsp_in.dist_squared = vdn_pkg::DIST_OUT_W'(side_ff[ST-1].dsq);
      rsp_in.length_q8    = vdn_pkg::LEN_OUT_W'(len_root);
      rsp_in.unit_x       = unit_val[0];
      rsp_in.unit_y       = unit_val[1];
      rsp_in.unit_z       = unit_val[2];
      rsp_in.zero_length  = side_ff[ST-1].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= {valid_ff[ST-2:0], in_valid};
         strobe_ff <= valid_ff[ST-1];
      end
      side_ff[0] <= side_in;
      for (int i = 1; i < ST; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== bench/tb_vector_distance_normalize.sv =====
// Testbench for vector_distance_normalize: drives point pairs, predicts distance,
// length and unit vector in fixed point, and checks every strobed result in order.
// Depends on vdn_pkg and the vector_distance_normalize RTL.
module tb_vector_distance_normalize;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 50;
   localparam int MAX_CYCLE = 400000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   vdn_pkg::req_type req_item;
   logic             rsp_strobe;
   vdn_pkg::rsp_type rsp_item;

   vdn_pkg::rsp_type expected_q[$];
   int               mismatch_count;
   int               cycle_count;
   int               idle_pct;

   vector_distance_normalize u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bitwise integer square root, floor.
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic signed [15:0] unit_of(longint d, longint unsigned dsq);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q   = int_sqrt(((mag * mag) << 28) / dsq);
      return (d < 0) ? -q[15:0] : q[15:0];
   endfunction

   function automatic vdn_pkg::rsp_type predict_distance(vdn_pkg::req_type r);
      vdn_pkg::rsp_type p;
      longint           dx, dy, dz;
      longint unsigned  dsq;
      longint unsigned  len;
      dx  = longint'(r.a_x) - longint'(r.b_x);
      dy  = longint'(r.a_y) - longint'(r.b_y);
      dz  = longint'(r.a_z) - longint'(r.b_z);
      dsq = dx * dx + dy * dy + dz * dz;
      p = '0;
      p.dist_squared = dsq[33:0];
      if (dsq == 0) begin
         p.zero_length = 1'b1;
      end else begin
         len         = int_sqrt(dsq << 16);
         p.length_q8 = len[24:0];
         p.unit_x    = unit_of(dx, dsq);
         p.unit_y    = unit_of(dy, dsq);
         p.unit_z    = unit_of(dz, dsq);
      end
      return p;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Check each strobed item against the oldest prediction.
   always @(posedge clock) begin
      vdn_pkg::rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("mismatch: result with no item outstanding");
            mismatch_count++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_item.dist_squared != e.dist_squared)
               report("dist_squared", rsp_item.dist_squared, e.dist_squared);
            if (rsp_item.length_q8 != e.length_q8)
               report("length_q8", rsp_item.length_q8, e.length_q8);
            if (rsp_item.unit_x != e.unit_x) report("unit_x", rsp_item.unit_x, e.unit_x);
            if (rsp_item.unit_y != e.unit_y) report("unit_y", rsp_item.unit_y, e.unit_y);
            if (rsp_item.unit_z != e.unit_z) report("unit_z", rsp_item.unit_z, e.unit_z);
            if (rsp_item.zero_length !== e.zero_length)
               report("zero_length", rsp_item.zero_length, e.zero_length);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Hold start until accepted; leave it high when the next item follows at once.
   task automatic send_item(vdn_pkg::req_type r);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.push_back(predict_distance(r));
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(7)) - 16'd3;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic vdn_pkg::req_type pair(int ax, int ay, int az, int bx, int by, int bz);
      vdn_pkg::req_type r;
      r.a_x = 16'(ax); r.a_y = 16'(ay); r.a_z = 16'(az);
      r.b_x = 16'(bx); r.b_y = 16'(by); r.b_z = 16'(bz);
      return r;
   endfunction

   task automatic test_directed();
      idle_pct = 0;
      send_item(pair(0, 0, 0, 0, 0, 0));
      send_item(pair(1234, -77, 32767, 1234, -77, 32767));
      send_item(pair(32767, 32767, 32767, -32768, -32768, -32768));
      send_item(pair(-32768, -32768, -32768, 32767, 32767, 32767));
      send_item(pair(32767, -32768, 32767, -32768, 32767, -32768));
      send_item(pair(5, 0, 0, 0, 0, 0));
      send_item(pair(0, -9, 0, 0, 0, 0));
      send_item(pair(0, 0, 0, 0, 0, 32767));
      send_item(pair(-32768, 0, 0, 32767, 0, 0));
      send_item(pair(1, 1, 1, 0, 0, 0));
      send_item(pair(1, 0, 0, 0, 1, 0));
      send_item(pair(3, 4, 12, 0, 0, 0));
      send_item(pair(-1, -1, 0, 0, 0, 0));
      send_item(pair(1, 2, 3, 0, 0, 0));
      send_item(pair(-32768, -32768, -32768, 0, 0, 0));
      send_item(pair(32767, 1, 0, 0, 0, 0));
      drain();
   endtask

   task automatic test_random(int pct, int count);
      vdn_pkg::req_type r;
      idle_pct = pct;
      repeat (count) begin
         r.a_x = rand_comp(); r.a_y = rand_comp(); r.a_z = rand_comp();
         r.b_x = rand_comp(); r.b_y = rand_comp(); r.b_z = rand_comp();
         // Occasionally force an axis or zero difference.
         if ($urandom_range(9) == 0) begin r.b_y = r.a_y; r.b_z = r.a_z; end
         if ($urandom_range(19) == 0) r.b_x = r.a_x;
         send_item(r);
      end
      // Let everything in flight come back before the next phase.
      drain();
   endtask

   initial begin
      mismatch_count = 0;
      cycle_count    = 0;
      idle_pct       = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(0, 150);
      test_random(54, 150);
      test_random(13, 150);
      test_random(0, 150);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/vdn_pkg.sv
hw/rtl/vdn_front.sv
hw/rtl/vdn_queue.sv
hw/rtl/vdn_div.sv
hw/rtl/vdn_isqrt.sv
hw/rtl/vdn_back.sv
hw/rtl/vector_distance_normalize.sv
bench/tb_vector_distance_normalize.sv
